// ----- rtl/pcs_pkg.sv -----
// pcs_pkg: payload types and fixed field widths for the peak counter.
// Used by pcs_front, pcs_back, the top module and the checker; depends on nothing.
`default_nettype none

package pcs_pkg;

  localparam int PC_W   = 13;
  localparam int SD_W   = 20;
  localparam int FRAC_W = 16;
  localparam int BAND_W = 31;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               last_sample;
  } pcs_in_t;

  typedef struct packed {
    logic [PC_W-1:0] peak_count;
    logic [SD_W-1:0] spacing_std_dev;
    logic            too_long;
  } pcs_out_t;

endpackage

`default_nettype wire

// ----- rtl/pcs_front.sv -----
// pcs_front: per-beat peak detection with dead band, spacing sums, length guard.
// Pushes one summary per sequence into the summary queue. Depends on pcs_pkg.
`default_nettype none

module pcs_front #(
  parameter int MAX_LEN = 4096,
  localparam int IW = $clog2(MAX_LEN + 1),
  localparam int PW = $clog2(MAX_LEN)
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               push,
  output logic                              full,
  input  pcs_pkg::pcs_in_t                  item,
  input  wire                               dead_band_wr,
  input  wire  [pcs_pkg::BAND_W-1:0]        dead_band,
  output logic                              q_push,
  input  wire                               q_full,
  output logic [IW-1:0]                     q_peaks,
  output logic [IW-1:0]                     q_ssum,
  output logic [2*IW-1:0]                   q_sqsum,
  output logic                              q_ovf
);
  import pcs_pkg::*;

  logic [BAND_W-1:0]  band;
  logic signed [31:0] prev;
  logic               rising;
  logic [IW-1:0]      idx;
  logic [PW-1:0]      lpk;
  logic               have_pk;
  logic [IW-1:0]      peaks;
  logic [IW-1:0]      ssum;
  logic [2*IW-1:0]    sqsum;
  logic               ovf;

  logic               acc;
  logic               last;
  logic               at_max;
  logic               in_range;
  logic signed [32:0] diff;
  logic signed [32:0] band_s;
  logic               start_pk;
  logic               rise_eff;
  logic               dir_next;
  logic               turn_pk;
  logic               end_pk;
  logic               any_pk;
  logic               add_gap;
  logic [PW-1:0]      pk_at;
  logic [PW-1:0]      gap;
  logic [2*PW-1:0]    gap_sq;

  logic               rising_next;
  logic               ovf_next;
  logic [IW-1:0]      peaks_next;
  logic [IW-1:0]      ssum_next;
  logic [2*IW-1:0]    sqsum_next;
  logic [PW-1:0]      lpk_next;
  logic               have_pk_next;
  logic [IW-1:0]      idx_next;

  assign full     = q_full;
  assign acc      = push && !full;
  assign last     = item.last_sample;
  assign at_max   = (idx == IW'(MAX_LEN));
  assign in_range = !ovf && !at_max && (idx != '0);

  always_comb begin
    diff     = {item.sample[31], item.sample} - {prev[31], prev};
    band_s   = signed'({2'b00, band});
    start_pk = in_range && (idx == IW'(1)) && (prev > item.sample);
    rise_eff = rising && !start_pk;
    dir_next = rise_eff;
    if (diff >= band_s) begin
      dir_next = 1'b1;
    end
    if (diff <= -band_s) begin
      dir_next = 1'b0;
    end
    turn_pk  = in_range && !last && rise_eff && !dir_next;
    end_pk   = in_range && last && (item.sample > prev);
    any_pk   = start_pk || turn_pk || end_pk;
    add_gap  = any_pk && have_pk;
    pk_at    = start_pk ? '0 : idx[PW-1:0];
    gap      = pk_at - lpk;
    gap_sq   = {{PW{1'b0}}, gap} * {{PW{1'b0}}, gap};

    rising_next = rising;
    if (in_range) begin
      if (last) begin
        rising_next = rise_eff;
      end else begin
        rising_next = dir_next;
      end
    end
    ovf_next     = ovf || at_max;
    peaks_next   = peaks + IW'(any_pk);
    ssum_next    = add_gap ? ssum + IW'(gap) : ssum;
    sqsum_next   = add_gap ? sqsum + (2*IW)'(gap_sq) : sqsum;
    lpk_next     = any_pk ? pk_at : lpk;
    have_pk_next = have_pk || any_pk;
    idx_next     = at_max ? idx : idx + IW'(1);
  end

  assign q_push  = acc && last;
  assign q_peaks = peaks_next;
  assign q_ssum  = ssum_next;
  assign q_sqsum = sqsum_next;
  assign q_ovf   = ovf_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      band <= BAND_W'(7);
    end else if (dead_band_wr) begin
      band <= dead_band;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev    <= '0;
      rising  <= 1'b1;
      idx     <= '0;
      lpk     <= '0;
      have_pk <= 1'b0;
      peaks   <= '0;
      ssum    <= '0;
      sqsum   <= '0;
      ovf     <= 1'b0;
    end else if (acc) begin
      if (last) begin
        prev    <= '0;
        rising  <= 1'b1;
        idx     <= '0;
        lpk     <= '0;
        have_pk <= 1'b0;
        peaks   <= '0;
        ssum    <= '0;
        sqsum   <= '0;
        ovf     <= 1'b0;
      end else begin
        prev    <= item.sample;
        rising  <= rising_next;
        idx     <= idx_next;
        lpk     <= lpk_next;
        have_pk <= have_pk_next;
        peaks   <= peaks_next;
        ssum    <= ssum_next;
        sqsum   <= sqsum_next;
        ovf     <= ovf_next;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pcs_fifo.sv -----
// pcs_fifo: two-entry queue for per-sequence summaries between front and back.
// Generic width; no package dependency.
`default_nettype none

module pcs_fifo #(
  parameter int W = 53
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          wr,
  input  wire  [W-1:0] wdata,
  output logic         q_full,
  input  wire          rd,
  output logic [W-1:0] rdata,
  output logic         q_empty
);

  logic [W-1:0] mem [2];
  logic         wp;
  logic         rp;
  logic [1:0]   cnt;
  logic         do_wr;
  logic         do_rd;

  assign q_full  = (cnt == 2'd2);
  assign q_empty = (cnt == 2'd0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rdata   = mem[rp];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_wr) begin
        wp <= !wp;
      end
      if (do_rd) begin
        rp <= !rp;
      end
      cnt <= cnt + 2'(do_wr) - 2'(do_rd);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pcs_back.sv -----
// pcs_back: per-sequence spread: multiplies, bit-serial divide, digit-serial root.
// Holds one finished result for the output side. Depends on pcs_pkg.
`default_nettype none

module pcs_back #(
  parameter int MAX_LEN = 4096,
  localparam int IW = $clog2(MAX_LEN + 1)
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                q_empty,
  output logic               q_pop,
  input  wire  [IW-1:0]      q_peaks,
  input  wire  [IW-1:0]      q_ssum,
  input  wire  [2*IW-1:0]    q_sqsum,
  input  wire                q_ovf,
  output logic               empty,
  input  wire                pop,
  output pcs_pkg::pcs_out_t  result
);
  import pcs_pkg::*;

  localparam int DW  = 3*IW + FRAC_W;
  localparam int VW  = 2*IW + FRAC_W;
  localparam int RTW = VW / 2;
  localparam int CW  = $clog2(DW);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_SUB  = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_SQRT = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t          state;
  logic [IW-1:0]   pk;
  logic [IW-1:0]   s_sum;
  logic [2*IW-1:0] sq_sum;
  logic            ovf;
  logic [3*IW-1:0] num;
  logic [2*IW-1:0] ss2;
  logic [2*IW-1:0] den;
  logic            few;
  logic [DW-1:0]   dq;
  logic [2*IW-1:0] drem;
  logic [VW-1:0]   sx;
  logic [RTW+1:0]  srem;
  logic [RTW-1:0]  root;
  logic [CW-1:0]   cnt;
  logic            res_valid;
  pcs_out_t        res;

  logic [IW-1:0]     n;
  logic [3*IW-1:0]   ss2_ext;
  logic [3*IW-1:0]   var_num;
  logic [2*IW:0]     dt;
  logic [2*IW:0]     dsub;
  logic              dge;
  logic [2*IW-1:0]   drem_next;
  logic [DW-1:0]     dq_next;
  logic [RTW+3:0]    st;
  logic [RTW+3:0]    trial;
  logic [RTW+3:0]    ssub;
  logic              sge;
  logic [RTW+1:0]    srem_next;
  logic [RTW-1:0]    root_next;
  logic [IW+PC_W-1:0] pc_ext;
  logic [RTW+SD_W-1:0] sd_ext;
  logic [PC_W-1:0]   pc_sat;
  logic [SD_W-1:0]   sd_sat;
  logic              load;

  always_comb begin
    n         = pk - IW'(1);
    ss2_ext   = {{IW{1'b0}}, ss2};
    var_num   = num - ss2_ext;
    dt        = {drem, dq[DW-1]};
    dsub      = dt - {1'b0, den};
    dge       = (dt >= {1'b0, den});
    drem_next = dge ? dsub[2*IW-1:0] : dt[2*IW-1:0];
    dq_next   = {dq[DW-2:0], dge};
    st        = {srem, sx[VW-1:VW-2]};
    trial     = {2'b00, root, 2'b01};
    ssub      = st - trial;
    sge       = (st >= trial);
    srem_next = sge ? ssub[RTW+1:0] : st[RTW+1:0];
    root_next = {root[RTW-2:0], sge};
    pc_ext    = {{PC_W{1'b0}}, pk};
    pc_sat    = (|pc_ext[IW+PC_W-1:PC_W]) ? '1 : pc_ext[PC_W-1:0];
    sd_ext    = {{SD_W{1'b0}}, root};
    sd_sat    = (|sd_ext[RTW+SD_W-1:SD_W]) ? '1 : sd_ext[SD_W-1:0];
  end

  assign q_pop  = (state == ST_IDLE) && !q_empty;
  assign load   = (state == ST_DONE) && (!res_valid || pop);
  assign empty  = !res_valid;
  assign result = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_SUB;
        end
        ST_SUB: begin
          cnt <= '0;
          if (few || (num < ss2_ext)) begin
            state <= ST_DONE;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (cnt == CW'(DW - 1)) begin
            cnt   <= '0;
            state <= ST_SQRT;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        ST_SQRT: begin
          if (cnt == CW'(RTW - 1)) begin
            state <= ST_DONE;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        ST_DONE: begin
          if (load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        pk     <= q_peaks;
        s_sum  <= q_ssum;
        sq_sum <= q_sqsum;
        ovf    <= q_ovf;
      end
      ST_MUL: begin
        num <= {{(2*IW){1'b0}}, n} * {{IW{1'b0}}, sq_sum};
        ss2 <= {{IW{1'b0}}, s_sum} * {{IW{1'b0}}, s_sum};
        den <= {{IW{1'b0}}, n} * {{IW{1'b0}}, n};
        few <= (pk < IW'(3));
      end
      ST_SUB: begin
        dq   <= {var_num, {FRAC_W{1'b0}}};
        drem <= '0;
        root <= '0;
      end
      ST_DIV: begin
        dq   <= dq_next;
        drem <= drem_next;
        if (cnt == CW'(DW - 1)) begin
          sx   <= dq_next[VW-1:0];
          srem <= '0;
          root <= '0;
        end
      end
      ST_SQRT: begin
        sx   <= {sx[VW-3:0], 2'b00};
        srem <= srem_next;
        root <= root_next;
      end
      ST_DONE: begin
        if (load) begin
          res.peak_count      <= pc_sat;
          res.spacing_std_dev <= sd_sat;
          res.too_long        <= ovf;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/peak_count_spacing_stddev.sv -----
// peak_count_spacing_stddev: peak counter with dead band and spacing spread.
// Instantiates pcs_front, pcs_fifo and pcs_back; depends on pcs_pkg.
//
//   channel   handshake          beat
//   input     push / full        item: sample, last_sample
//   result    empty / pop        result: peak_count, spacing_std_dev, too_long
//   config    dead_band_wr       dead_band (31 bits, reset 7)
//
// The front takes one sample beat per cycle while full is low. Each last beat queues a summary
// (two entries deep); full rises while that queue is full, stalling input.
// The back takes one sequence at a time: 3*IW+16 divide steps and IW+8 root
// steps (IW = clog2(MAX_LEN+1)) after its multiply and subtract states, none
// with fewer than three peaks or a negative variance. One finished result waits
// in the output register while the next is worked on. rst clears control state.
`default_nettype none

module peak_count_spacing_stddev #(
  parameter int MAX_LEN = 4096
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        push,
  output logic                       full,
  input  pcs_pkg::pcs_in_t           item,
  output logic                       empty,
  input  wire                        pop,
  output pcs_pkg::pcs_out_t          result,
  input  wire                        dead_band_wr,
  input  wire  [pcs_pkg::BAND_W-1:0] dead_band
);
  import pcs_pkg::*;

  localparam int IW = $clog2(MAX_LEN + 1);
  localparam int QW = 4*IW + 1;

  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_empty;
  logic [IW-1:0]   f_peaks;
  logic [IW-1:0]   f_ssum;
  logic [2*IW-1:0] f_sqsum;
  logic            f_ovf;
  logic [QW-1:0]   q_rdata;

  pcs_front #(.MAX_LEN(MAX_LEN)) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .item         (item),
    .dead_band_wr (dead_band_wr),
    .dead_band    (dead_band),
    .q_push       (q_push),
    .q_full       (q_full),
    .q_peaks      (f_peaks),
    .q_ssum       (f_ssum),
    .q_sqsum      (f_sqsum),
    .q_ovf        (f_ovf)
  );

  pcs_fifo #(.W(QW)) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wdata   ({f_ovf, f_sqsum, f_ssum, f_peaks}),
    .q_full  (q_full),
    .rd      (q_pop),
    .rdata   (q_rdata),
    .q_empty (q_empty)
  );

  pcs_back #(.MAX_LEN(MAX_LEN)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_peaks (q_rdata[IW-1:0]),
    .q_ssum  (q_rdata[2*IW-1:IW]),
    .q_sqsum (q_rdata[4*IW-1:2*IW]),
    .q_ovf   (q_rdata[4*IW]),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

  a_queue_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("summary queue written while full");

  a_few_peaks_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && (result.peak_count < PC_W'(3))) |-> (result.spacing_std_dev == '0))
    else $error("nonzero spread with fewer than three peaks");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (32'(result.peak_count) <= 32'(MAX_LEN)))
    else $error("peak count above sequence length");

endmodule

`default_nettype wire

// ----- dv/pcs_checker.sv -----
// pcs_checker: predicts peak count, spacing spread and overrun flag per sequence
// and compares every popped result beat in order. Depends on pcs_pkg.
module pcs_checker #(
  parameter int MAX_LEN = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic                       full,
  input  pcs_pkg::pcs_in_t           item,
  input  logic                       empty,
  input  logic                       pop,
  input  pcs_pkg::pcs_out_t          result,
  input  logic                       dead_band_wr,
  input  logic [pcs_pkg::BAND_W-1:0] dead_band,
  output int                         errors,
  output int                         pending
);
  import pcs_pkg::*;

  logic [BAND_W-1:0] band_q;
  logic signed [31:0] prev_s;
  logic               dir_up;
  logic [12:0]        pos;
  logic [11:0]        last_peak_at;
  logic               peak_known;
  logic [12:0]        peak_total;
  logic [23:0]        gap_sum;
  logic [35:0]        gap_sq_sum;
  logic               overrun;
  pcs_out_t           owed_summaries[$];

  initial errors = 0;
  initial pending = 0;

  task automatic report(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic restart_sequence();
    prev_s = '0;
    dir_up = 1'b1;
    pos = '0;
    last_peak_at = '0;
    peak_known = 1'b0;
    peak_total = '0;
    gap_sum = '0;
    gap_sq_sum = '0;
    overrun = 1'b0;
  endtask

  task automatic note_peak(input logic [12:0] at);
    logic [11:0] gap;
    if (peak_known) begin
      gap = (at[11:0] >= last_peak_at) ? at[11:0] - last_peak_at : last_peak_at - at[11:0];
      gap_sum = gap_sum + gap;
      gap_sq_sum = gap_sq_sum + gap * gap;
    end
    peak_total = peak_total + 1'b1;
    last_peak_at = at[11:0];
    peak_known = 1'b1;
  endtask

  function automatic logic [SD_W-1:0] spread_of(input logic [12:0] peaks,
                                                input logic [23:0] s,
                                                input logic [35:0] ss);
    logic [63:0] n, num, sq, den, v, root, trial;
    if (peaks < 3) return '0;
    n = peaks;
    n = n - 1;
    num = n * ss;
    sq = s;
    sq = sq * sq;
    if (num < sq) return '0;
    num = num - sq;
    den = n * n;
    v = ((num / den) << 16) + (((num % den) << 16) / den);
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return (root > 64'd1048575) ? '1 : root[SD_W-1:0];
  endfunction

  task automatic fold_sample(input pcs_in_t beat);
    logic signed [31:0] cur;
    logic signed [32:0] diff;
    logic signed [32:0] lim;
    logic               next_up;
    pcs_out_t           summary;
    cur = beat.sample;
    if (!overrun) begin
      if (pos >= MAX_LEN) begin
        overrun = 1'b1;
      end else if (pos >= 1) begin
        if (pos == 1 && prev_s > cur) begin
          note_peak('0);
          dir_up = 1'b0;
        end
        if (beat.last_sample) begin
          if (cur > prev_s) note_peak(pos);
        end else begin
          diff = $signed({cur[31], cur}) - $signed({prev_s[31], prev_s});
          lim = $signed({2'b00, band_q});
          next_up = dir_up;
          if (diff >= lim) next_up = 1'b1;
          if (diff <= -lim) next_up = 1'b0;
          if (dir_up && !next_up) note_peak(pos);
          dir_up = next_up;
        end
      end
    end
    prev_s = cur;
    if (pos < MAX_LEN) pos = pos + 1'b1;
    if (beat.last_sample) begin
      summary.peak_count = peak_total;
      summary.spacing_std_dev = spread_of(peak_total, gap_sum, gap_sq_sum);
      summary.too_long = overrun;
      owed_summaries.push_back(summary);
      restart_sequence();
    end
  endtask

  task automatic check_result(input pcs_out_t got);
    pcs_out_t want;
    if (owed_summaries.size() == 0) begin
      report("result beat with no sequence outstanding");
      return;
    end
    want = owed_summaries.pop_front();
    if (got.peak_count !== want.peak_count)
      report($sformatf("peak_count %0d, expected %0d", got.peak_count, want.peak_count));
    if (got.spacing_std_dev !== want.spacing_std_dev)
      report($sformatf("spacing_std_dev %0d, expected %0d",
                       got.spacing_std_dev, want.spacing_std_dev));
    if (got.too_long !== want.too_long)
      report($sformatf("too_long %0b, expected %0b", got.too_long, want.too_long));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      band_q = 7;
      restart_sequence();
      owed_summaries.delete();
    end else begin
      if (push && !full) fold_sample(item);
      if (dead_band_wr) band_q = dead_band;
      if (pop && !empty) check_result(result);
    end
    pending <= owed_summaries.size();
  end

endmodule

// ----- dv/tb_peak_count_spacing_stddev.sv -----
// tb_peak_count_spacing_stddev: drives sample sequences and dead band settings
// into peak_count_spacing_stddev under several pacing phases and gives the verdict.
// Depends on pcs_pkg, the block and pcs_checker.
module tb_peak_count_spacing_stddev;
  import pcs_pkg::*;

  localparam int MAX_LEN = 4096;
  localparam int LIMIT   = 1000000;
  localparam int SETTLE  = 200;
  localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S_MIN = 32'h8000_0000;

  typedef enum int {SHAPE_WALK, SHAPE_NOISE, SHAPE_SAW, SHAPE_RAIL} shape_e;
  typedef enum int {PACE_FREE, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_e;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              push = 1'b0;
  logic              pop = 1'b0;
  logic              dead_band_wr = 1'b0;
  logic [BAND_W-1:0] dead_band = '0;
  pcs_in_t           item = '0;
  logic              full, empty;
  pcs_out_t          result;
  int                send_idle = 0;
  int                recv_stall = 0;
  int                errors, pending;
  int                cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  peak_count_spacing_stddev #(.MAX_LEN(MAX_LEN)) dut (
    .clk, .rst, .push, .full, .item, .empty, .pop, .result, .dead_band_wr, .dead_band
  );

  pcs_checker #(.MAX_LEN(MAX_LEN)) u_check (
    .clk, .rst, .push, .full, .item, .empty, .pop, .result, .dead_band_wr, .dead_band,
    .errors, .pending
  );

  always @(posedge clk) pop <= !rst && ($urandom_range(99) >= recv_stall);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic set_pace(input pace_e pace);
    case (pace)
      PACE_FREE: begin
        send_idle = 0;
        recv_stall = 0;
      end
      PACE_SEND_IDLE: begin
        send_idle = 59;
        recv_stall = 0;
      end
      PACE_RECV_STALL: begin
        send_idle = 0;
        recv_stall = 59;
      end
      default: begin
        send_idle = 6;
        recv_stall = 6;
      end
    endcase
  endtask

  task automatic send_beat(input logic [31:0] s, input logic l);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item.sample <= s;
    item.last_sample <= l;
    do @(posedge clk); while (full);
  endtask

  task automatic send_vals(input int n, input logic [31:0] v0, v1, v2, v3, v4, v5);
    logic [31:0] v[6];
    v[0] = v0; v[1] = v1; v[2] = v2; v[3] = v3; v[4] = v4; v[5] = v5;
    for (int i = 0; i < n; i++) send_beat(v[i], i == n - 1);
  endtask

  task automatic send_run(input int len, input shape_e shape);
    longint      lvl, span, step;
    logic [31:0] s;
    lvl = longint'($signed($urandom()));
    for (int i = 0; i < len; i++) begin
      case (shape)
        SHAPE_WALK: begin
          span = longint'(dead_band) * 2 + 16;
          if (span > 64'sd4294967294) span = 64'sd4294967294;
          step = longint'($urandom_range(span)) - span / 2;
          lvl = lvl + step;
          if (lvl > 64'sd2147483647) lvl = 64'sd2147483647;
          if (lvl < -64'sd2147483648) lvl = -64'sd2147483648;
          s = lvl[31:0];
        end
        SHAPE_NOISE: s = $urandom();
        SHAPE_SAW:   s = i[0] ? S_MIN : S_MAX;
        default: begin
          case ($urandom_range(5))
            0: s = S_MAX;
            1: s = S_MIN;
            2: s = 32'h0;
            3: s = 32'hFFFF_FFFF;
            4: s = 32'h1;
            default: s = $urandom();
          endcase
        end
      endcase
      send_beat(s, i == len - 1);
    end
  endtask

  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_band(input logic [BAND_W-1:0] v);
    dead_band_wr <= 1'b1;
    dead_band <= v;
    @(posedge clk);
    dead_band_wr <= 1'b0;
  endtask

  function automatic logic [BAND_W-1:0] band_for_phase(input int p);
    case (p)
      0: return 31'd7;
      1: return 31'd0;
      2: return 31'h7FFF_FFFF;
      3: return 31'd1;
      4: return 31'h0001_0000;
      5: return BAND_W'($urandom());
      default: return BAND_W'($urandom_range(1000));
    endcase
  endfunction

  initial begin
    int sent, len, pick;
    shape_e shape;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < 7; p++) begin
      if (p > 0) settle();
      write_band(band_for_phase(p));
      set_pace(pace_e'(p % 4));
      case (p)
        0: begin
          send_vals(1, 32'd0, 0, 0, 0, 0, 0);
          send_vals(2, S_MAX, S_MIN, 0, 0, 0, 0);
          send_vals(2, S_MIN, S_MAX, 0, 0, 0, 0);
          send_vals(4, 32'd0, 32'd100, 32'd0, 32'd50, 0, 0);
          send_vals(6, 32'd10, 32'd3, 32'd0, 32'd3, 32'd0, 32'd20);
          send_vals(5, S_MIN, S_MAX, S_MIN, S_MAX, 32'd0, 0);
        end
        1: send_vals(5, 32'd0, 32'd5, 32'd5, 32'd5, 32'd0, 0);
        default: ;
      endcase
      sent = 0;
      while (sent < 120) begin
        pick = $urandom_range(99);
        if (pick < 10) len = 1;
        else if (pick < 20) len = $urandom_range(3, 2);
        else if (pick < 85) len = $urandom_range(40, 4);
        else len = $urandom_range(200, 41);
        pick = $urandom_range(99);
        if (pick < 60) shape = SHAPE_WALK;
        else if (pick < 75) shape = SHAPE_NOISE;
        else if (pick < 88) shape = SHAPE_SAW;
        else shape = SHAPE_RAIL;
        send_run(len, shape);
        sent += len;
      end
    end
    settle();
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/pcs_pkg.sv
rtl/pcs_front.sv
rtl/pcs_fifo.sv
rtl/pcs_back.sv
rtl/peak_count_spacing_stddev.sv
dv/pcs_checker.sv
dv/tb_peak_count_spacing_stddev.sv
